// File: src/ert_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ert_pkg;

    localparam int MAX_ACTIVE    = 16;
    localparam int RETIRED_DEPTH = 16;
    localparam int ID_WIDTH      = 32;
    localparam int MAX_RESULTS   = 16;

    localparam int AIDX_W = (MAX_ACTIVE > 1) ? $clog2(MAX_ACTIVE) : 1;
    localparam int QIDX_W = (RETIRED_DEPTH > 1) ? $clog2(RETIRED_DEPTH) : 1;
    localparam int FILL_W = $clog2(RETIRED_DEPTH + 1);
    localparam int NCNT_W = $clog2(MAX_RESULTS + 1);
    localparam int CMP_W  = (ID_WIDTH > 32) ? ID_WIDTH : 32;

    localparam logic [1:0] ACT_START  = 2'd0;
    localparam logic [1:0] ACT_RETIRE = 2'd1;
    localparam logic [1:0] ACT_END    = 2'd2;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_ACTIVE_FULL = 3'd1;
    localparam logic [2:0] ST_QUEUE_FULL  = 3'd2;
    localparam logic [2:0] ST_IDS_OUT     = 3'd3;
    localparam logic [2:0] ST_UNKNOWN     = 3'd4;

    typedef struct packed {
        logic capture;
        logic single;
        logic scan_step;
        logic pop;
        logic emit_pending;
        logic emit_final;
    } ert_cmd_t;

    typedef struct packed {
        logic is_end;
        logic scan_last;
        logic eligible;
        logic pend_valid;
        logic out_free;
    } ert_sts_t;

endpackage

`default_nettype wire

// File: src/ert_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ert_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire ert_pkg::ert_sts_t sts,
    output ert_pkg::ert_cmd_t     cmd
);
    import ert_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ONE,
        S_SCAN,
        S_POP,
        S_FIN
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = sts.is_end ? S_SCAN : S_ONE;
                end
            end
            S_ONE: begin
                if (sts.out_free)
                begin
                    cmd.single = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_POP;
                end
            end
            S_POP: begin
                // one batch buffered so the final one can carry last
                if (!sts.eligible)
                begin
                    state_next = S_FIN;
                end
                else if (!sts.pend_valid || sts.out_free)
                begin
                    cmd.pop          = 1'b1;
                    cmd.emit_pending = sts.pend_valid;
                end
            end
            S_FIN: begin
                if (sts.out_free)
                begin
                    cmd.emit_final = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    a_pop_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pop && sts.pend_valid) |-> sts.out_free)
        else $error("pop would overwrite an undelivered result");

    a_fin_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |-> ($past(state_reg) == S_POP || $past(state_reg) == S_FIN))
        else $error("final result reached without release pass");

    a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && sts.scan_last) |=> (state_reg == S_POP))
        else $error("scan did not hand over to release");

endmodule

`default_nettype wire

// File: src/ert_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module ert_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [1:0]        action,
    input  wire logic [31:0]       txn_id,
    input  wire logic [15:0]       batch_handle,
    input  wire logic [7:0]        batch_count,
    input  wire ert_pkg::ert_cmd_t cmd,
    output ert_pkg::ert_sts_t      sts,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [2:0]             status,
    output logic [31:0]            assigned_id,
    output logic                   released_valid,
    output logic [15:0]            released_handle,
    output logic                   last
);
    import ert_pkg::*;

    // captured request
    logic [1:0]  action_reg, action_next;
    logic [31:0] txn_reg, txn_next;
    logic [15:0] handle_reg, handle_next;
    logic [7:0]  count_reg, count_next;

    // persistent state
    logic [ID_WIDTH-1:0]   next_id_reg, next_id_next;
    logic [MAX_ACTIVE-1:0] valid_reg, valid_next;
    logic [ID_WIDTH-1:0]   active_id_reg [MAX_ACTIVE];
    logic [ID_WIDTH-1:0]   q_stamp_reg [RETIRED_DEPTH];
    logic [15:0]           q_handle_reg [RETIRED_DEPTH];
    logic [QIDX_W-1:0]     head_reg, head_next;
    logic [QIDX_W-1:0]     tail_reg, tail_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;

    // end processing
    logic [AIDX_W-1:0]   scan_reg, scan_next;
    logic [ID_WIDTH-1:0] oldest_reg, oldest_next;
    logic                found_reg, found_next;
    logic [NCNT_W-1:0]   rel_cnt_reg, rel_cnt_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [15:0]         pend_handle_reg, pend_handle_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  status_reg, status_next;
    logic [31:0] assigned_reg, assigned_next;
    logic        rel_valid_reg, rel_valid_next;
    logic [15:0] rel_handle_reg, rel_handle_next;
    logic        last_reg, last_next;

    logic              aid_we;
    logic              q_we;
    logic              free_found;
    logic [AIDX_W-1:0] free_slot;
    logic              out_free;
    logic              eligible;
    logic [2:0]        end_status;
    logic              e_valid;
    logic [ID_WIDTH-1:0] e_id;

    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = MAX_ACTIVE - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_slot  = AIDX_W'(i);
            end
        end
    end

    assign out_free   = !out_valid_reg || !out_stall;
    assign eligible   = (fill_reg != '0) && (q_stamp_reg[head_reg] <= oldest_reg)
                        && (rel_cnt_reg < NCNT_W'(MAX_RESULTS));
    assign end_status = found_reg ? ST_OK : ST_UNKNOWN;
    assign e_valid    = valid_reg[scan_reg];
    assign e_id       = active_id_reg[scan_reg];

    always_comb begin
        sts.is_end     = (action == ACT_END);
        sts.scan_last  = (scan_reg == AIDX_W'(MAX_ACTIVE - 1));
        sts.eligible   = eligible;
        sts.pend_valid = pend_valid_reg;
        sts.out_free   = out_free;
    end

    always_comb begin
        action_next      = action_reg;
        txn_next         = txn_reg;
        handle_next      = handle_reg;
        count_next       = count_reg;
        next_id_next     = next_id_reg;
        valid_next       = valid_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        fill_next        = fill_reg;
        scan_next        = scan_reg;
        oldest_next      = oldest_reg;
        found_next       = found_reg;
        rel_cnt_next     = rel_cnt_reg;
        pend_valid_next  = pend_valid_reg;
        pend_handle_next = pend_handle_reg;
        out_valid_next   = out_valid_reg && out_stall;
        status_next      = status_reg;
        assigned_next    = assigned_reg;
        rel_valid_next   = rel_valid_reg;
        rel_handle_next  = rel_handle_reg;
        last_next        = last_reg;
        aid_we           = 1'b0;
        q_we             = 1'b0;

        if (cmd.capture)
        begin
            action_next     = action;
            txn_next        = txn_id;
            handle_next     = batch_handle;
            count_next      = batch_count;
            scan_next       = '0;
            oldest_next     = next_id_reg;
            found_next      = 1'b0;
            rel_cnt_next    = '0;
            pend_valid_next = 1'b0;
        end

        if (cmd.single)
        begin
            out_valid_next  = 1'b1;
            status_next     = ST_OK;
            assigned_next   = '0;
            rel_valid_next  = 1'b0;
            rel_handle_next = '0;
            last_next       = 1'b1;
            unique case (action_reg)
                ACT_START: begin
                    if (next_id_reg == '1)
                    begin
                        status_next = ST_IDS_OUT;
                    end
                    else if (!free_found)
                    begin
                        status_next = ST_ACTIVE_FULL;
                    end
                    else
                    begin
                        aid_we                = 1'b1;
                        valid_next[free_slot] = 1'b1;
                        assigned_next         = 32'(next_id_reg);
                        next_id_next          = next_id_reg + ID_WIDTH'(1);
                    end
                end
                ACT_RETIRE: begin
                    if (count_reg != '0)
                    begin
                        if (fill_reg == FILL_W'(RETIRED_DEPTH))
                        begin
                            status_next = ST_QUEUE_FULL;
                        end
                        else
                        begin
                            q_we      = 1'b1;
                            tail_next = (tail_reg == QIDX_W'(RETIRED_DEPTH - 1)) ?
                                        '0 : tail_reg + QIDX_W'(1);
                            fill_next = fill_reg + FILL_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end

        if (cmd.scan_step)
        begin
            // ids are unique, so the ended id is simply left out of the minimum
            if (e_valid && (CMP_W'(e_id) == CMP_W'(txn_reg)))
            begin
                valid_next[scan_reg] = 1'b0;
                found_next           = 1'b1;
            end
            else if (e_valid && (e_id < oldest_reg))
            begin
                oldest_next = e_id;
            end
            scan_next = scan_reg + AIDX_W'(1);
        end

        if (cmd.pop)
        begin
            head_next        = (head_reg == QIDX_W'(RETIRED_DEPTH - 1)) ?
                               '0 : head_reg + QIDX_W'(1);
            fill_next        = fill_reg - FILL_W'(1);
            rel_cnt_next     = rel_cnt_reg + NCNT_W'(1);
            pend_handle_next = q_handle_reg[head_reg];
            pend_valid_next  = 1'b1;
        end

        if (cmd.emit_pending)
        begin
            out_valid_next  = 1'b1;
            status_next     = end_status;
            assigned_next   = '0;
            rel_valid_next  = 1'b1;
            rel_handle_next = pend_handle_reg;
            last_next       = 1'b0;
        end

        if (cmd.emit_final)
        begin
            out_valid_next  = 1'b1;
            status_next     = end_status;
            assigned_next   = '0;
            rel_valid_next  = pend_valid_reg;
            rel_handle_next = pend_valid_reg ? pend_handle_reg : 16'd0;
            last_next       = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_id_reg    <= '0;
            valid_reg      <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            fill_reg       <= '0;
            scan_reg       <= '0;
            found_reg      <= 1'b0;
            rel_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            next_id_reg    <= next_id_next;
            valid_reg      <= valid_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            fill_reg       <= fill_next;
            scan_reg       <= scan_next;
            found_reg      <= found_next;
            rel_cnt_reg    <= rel_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg      <= action_next;
        txn_reg         <= txn_next;
        handle_reg      <= handle_next;
        count_reg       <= count_next;
        oldest_reg      <= oldest_next;
        pend_handle_reg <= pend_handle_next;
        status_reg      <= status_next;
        assigned_reg    <= assigned_next;
        rel_valid_reg   <= rel_valid_next;
        rel_handle_reg  <= rel_handle_next;
        last_reg        <= last_next;
        if (aid_we)
        begin
            active_id_reg[free_slot] <= next_id_reg;
        end
        if (q_we)
        begin
            q_stamp_reg[tail_reg]  <= next_id_reg;
            q_handle_reg[tail_reg] <= handle_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign assigned_id     = assigned_reg;
    assign released_valid  = rel_valid_reg;
    assign released_handle = rel_handle_reg;
    assign last            = last_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(RETIRED_DEPTH))
        else $error("retired queue fill beyond depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (fill_reg != '0))
        else $error("release from empty queue");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.single || cmd.emit_pending || cmd.emit_final) |-> out_free)
        else $error("result loaded over an undelivered one");

    a_release_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rel_valid_reg) |-> (status_reg == ST_OK || status_reg == ST_UNKNOWN))
        else $error("released batch with a non-end status");

endmodule

`default_nettype wire

// File: src/epoch_reclamation_tracker.sv
// Epoch reclamation tracker.
// Input channel (in_valid / in_stall) carries one request: action selects
// start, retire or end; txn_id is used by end, batch_handle and batch_count
// by retire. Output channel (out_valid / out_stall) carries result items.
// Start, retire and the unused action give exactly one result with last set.
// End gives one result per released batch (at most 16), last on the final
// one, or a single result with released_valid low when nothing is freed.
// Requests are handled one at a time; in_stall is high from acceptance until
// the last result of that request has been loaded into the output register.
// Start and retire load their result in the ONE state once the output
// register is free. End walks the active set one slot per cycle to drop
// the ended id and find the oldest live id, then pops eligible batches
// from the retired queue one per cycle while the output can take the
// pending result, until the head is not eligible, then loads the final
// one. The next request is taken the cycle after the last result is loaded.
// A stall on the output holds the current result and delays loading of
// further results; the walk of the active set goes on meanwhile.
// Reset clears the id counter, the active set and the retired queue; no
// initialization sweep is needed, so requests are taken right after reset.
`timescale 1ns / 1ps
`default_nettype none

module epoch_reclamation_tracker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  action,
    input  wire logic [31:0] txn_id,
    input  wire logic [15:0] batch_handle,
    input  wire logic [7:0]  batch_count,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [31:0]      assigned_id,
    output logic             released_valid,
    output logic [15:0]      released_handle,
    output logic             last
);
    import ert_pkg::*;

    ert_cmd_t cmd;
    ert_sts_t sts;

    ert_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    ert_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .action          (action),
        .txn_id          (txn_id),
        .batch_handle    (batch_handle),
        .batch_count     (batch_count),
        .cmd             (cmd),
        .sts             (sts),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .assigned_id     (assigned_id),
        .released_valid  (released_valid),
        .released_handle (released_handle),
        .last            (last)
    );

endmodule

`default_nettype wire

// File: test/epoch_reclamation_tracker_tb.sv
`timescale 1ns / 1ps

module epoch_reclamation_tracker_tb;

    import ert_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 40;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] assigned_id;
        logic        released_valid;
        logic [15:0] released_handle;
        logic        last;
    } result_t;

    class release_scoreboard;
        logic [31:0] id_counter;
        bit          slot_busy[MAX_ACTIVE];
        logic [31:0] slot_id[MAX_ACTIVE];
        logic [31:0] batch_stamp[RETIRED_DEPTH];
        logic [15:0] batch_tag[RETIRED_DEPTH];
        int          q_head;
        int          q_fill;
        result_t     owed[$];
        int          mismatches;
        int          n_requests;
        int          n_results;
        int          n_freed;
        int          n_table_full;
        int          n_queue_full;
        int          n_unknown;

        function new();
            id_counter = '0;
            q_head = 0;
            q_fill = 0;
            mismatches = 0;
            n_requests = 0;
            n_results = 0;
            n_freed = 0;
            n_table_full = 0;
            n_queue_full = 0;
            n_unknown = 0;
            foreach (slot_busy[i])
                slot_busy[i] = 1'b0;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function void owe(result_t r);
            owed.insert(owed.size(), r);
        endfunction

        // pick any live transaction id; leaves id alone if none is live
        function bit pick_live(inout logic [31:0] id);
            int live[$];
            foreach (slot_busy[i])
                if (slot_busy[i])
                    live.insert(live.size(), i);
            if (live.size() == 0)
                return 1'b0;
            id = slot_id[live[$urandom_range(0, live.size() - 1)]];
            return 1'b1;
        endfunction

        function void note_request(logic [1:0] act, logic [31:0] txn,
                                   logic [15:0] tag, logic [7:0] cnt);
            int          slot;
            int          n;
            logic [2:0]  st;
            logic [31:0] oldest;
            n_requests++;
            case (act)
                ACT_START:
                begin
                    slot = -1;
                    foreach (slot_busy[i])
                        if (!slot_busy[i] && slot < 0)
                            slot = i;
                    if (id_counter == '1)
                        owe('{ST_IDS_OUT, 32'd0, 1'b0, 16'd0, 1'b1});
                    else if (slot < 0)
                    begin
                        n_table_full++;
                        owe('{ST_ACTIVE_FULL, 32'd0, 1'b0, 16'd0, 1'b1});
                    end
                    else
                    begin
                        slot_busy[slot] = 1'b1;
                        slot_id[slot] = id_counter;
                        owe('{ST_OK, id_counter, 1'b0, 16'd0, 1'b1});
                        id_counter = id_counter + 1;
                    end
                end
                ACT_RETIRE:
                begin
                    if (cnt != 0 && q_fill >= RETIRED_DEPTH)
                    begin
                        n_queue_full++;
                        owe('{ST_QUEUE_FULL, 32'd0, 1'b0, 16'd0, 1'b1});
                    end
                    else
                    begin
                        if (cnt != 0)
                        begin
                            batch_stamp[(q_head + q_fill) % RETIRED_DEPTH] = id_counter;
                            batch_tag[(q_head + q_fill) % RETIRED_DEPTH] = tag;
                            q_fill++;
                        end
                        owe('{ST_OK, 32'd0, 1'b0, 16'd0, 1'b1});
                    end
                end
                ACT_END:
                begin
                    st = ST_UNKNOWN;
                    foreach (slot_busy[i])
                        if (st == ST_UNKNOWN && slot_busy[i] && slot_id[i] == txn)
                        begin
                            slot_busy[i] = 1'b0;
                            st = ST_OK;
                        end
                    if (st == ST_UNKNOWN)
                        n_unknown++;
                    oldest = id_counter;
                    foreach (slot_busy[i])
                        if (slot_busy[i] && slot_id[i] < oldest)
                            oldest = slot_id[i];
                    n = 0;
                    while (n < MAX_RESULTS && q_fill > 0 && batch_stamp[q_head] <= oldest)
                    begin
                        owe('{st, 32'd0, 1'b1, batch_tag[q_head], 1'b0});
                        q_head = (q_head + 1) % RETIRED_DEPTH;
                        q_fill--;
                        n++;
                    end
                    n_freed += n;
                    if (n == 0)
                        owe('{st, 32'd0, 1'b0, 16'd0, 1'b1});
                    else
                        owed[owed.size() - 1].last = 1'b1;
                end
                default:
                    owe('{ST_OK, 32'd0, 1'b0, 16'd0, 1'b1});
            endcase
        endfunction

        function void check_result(result_t got);
            result_t want;
            n_results++;
            if (owed.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result status=%0d id=%0d rel=%0b handle=%h last=%0b",
                             $time, got.status, got.assigned_id, got.released_valid,
                             got.released_handle, got.last);
                return;
            end
            want = owed.pop_front();
            if (got.status !== want.status || got.assigned_id !== want.assigned_id ||
                got.released_valid !== want.released_valid ||
                got.released_handle !== want.released_handle || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: expected status=%0d id=%0d rel=%0b handle=%h last=%0b",
                             $time, want.status, want.assigned_id, want.released_valid,
                             want.released_handle, want.last);
                    $display("%0t: got      status=%0d id=%0d rel=%0b handle=%h last=%0b",
                             $time, got.status, got.assigned_id, got.released_valid,
                             got.released_handle, got.last);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  action;
    logic [31:0] txn_id;
    logic [15:0] batch_handle;
    logic [7:0]  batch_count;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [31:0] assigned_id;
    logic        released_valid;
    logic [15:0] released_handle;
    logic        last;

    release_scoreboard book;
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    bit hold_req = 1'b0;
    int cycles = 0;

    epoch_reclamation_tracker DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("epoch_reclamation_tracker_tb failed");
                $finish;
            end
        end
    end

    // result side: random stall after each result while rx_idle is set, plus one long hold-off on request
    initial
    begin : result_sink
        int stall_left;
        result_t got;
        stall_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                got = '{status, assigned_id, released_valid, released_handle, last};
                book.check_result(got);
                stall_left = rx_idle ? $urandom_range(0, 18) : 0;
            end
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            out_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // called at a rising edge; returns at a rising edge after the request is taken
    task automatic send_request(input logic [1:0] act, input logic [31:0] txn,
                                input logic [15:0] tag, input logic [7:0] cnt);
        int gap;
        action       <= act;
        txn_id       <= txn;
        batch_handle <= tag;
        batch_count  <= cnt;
        in_valid     <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        book.note_request(act, txn, tag, cnt);
        gap = tx_idle ? $urandom_range(0, 18) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin : stimulus
        logic [31:0] txn;
        logic [15:0] tag;
        logic [7:0]  cnt;
        logic [31:0] base;
        int          r;
        int          starts_left;
        int          retires_left;

        book = new();
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        action       <= ACT_START;
        txn_id       <= '0;
        batch_handle <= '0;
        batch_count  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed corner cases
        send_request(ACT_END, 32'd5, 16'h0000, 8'h00);
        send_request(ACT_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
        send_request(ACT_RETIRE, 32'hFFFF_FFFF, 16'hFFFF, 8'h00);
        send_request(ACT_START, 32'h0, 16'h0, 8'h0);
        send_request(ACT_START, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
        send_request(ACT_RETIRE, 32'h0, 16'hFFFF, 8'hFF);
        send_request(ACT_RETIRE, 32'h0, 16'h0000, 8'h01);
        send_request(ACT_END, 32'd0, 16'h0, 8'h0);
        send_request(ACT_END, 32'hFFFF_FFFF, 16'h0, 8'h0);
        send_request(ACT_RETIRE, 32'h0, 16'hA5A5, 8'h80);
        send_request(ACT_END, 32'd1, 16'hFFFF, 8'hFF);
        send_request(ACT_END, 32'd1, 16'h0, 8'h0);
        send_request(ACT_START, 32'h0, 16'h0, 8'h0);
        send_request(ACT_RETIRE, 32'h0, 16'h5A5A, 8'h02);
        send_request(ACT_END, 32'h8000_0000, 16'h0, 8'h0);
        send_request(ACT_END, 32'd2, 16'h0, 8'h0);
        send_request(ACT_RETIRE, 32'h0, 16'h1234, 8'h03);
        // unknown id with an empty set still frees the queue
        send_request(ACT_END, 32'hDEAD_BEEF, 16'h0, 8'h0);

        // fill both tables past capacity while the result side holds off
        base = book.id_counter;
        tx_idle = 1'b0;
        hold_req = 1'b1;
        send_request(ACT_START, $urandom, 16'($urandom), 8'($urandom));
        starts_left = 16;
        retires_left = 17;
        while (starts_left + retires_left > 0)
        begin
            if (retires_left == 0 || (starts_left > 0 && $urandom_range(0, 1) == 1))
            begin
                send_request(ACT_START, $urandom, 16'($urandom), 8'($urandom));
                starts_left--;
            end
            else
            begin
                send_request(ACT_RETIRE, $urandom, 16'($urandom), 8'($urandom_range(1, 255)));
                retires_left--;
            end
        end

        // end newest first so the oldest id pins every batch until the final end
        tx_idle = 1'b1;
        for (int k = 15; k >= 0; k--)
        begin
            if (k == 7)
                send_request(ACT_END, $urandom, 16'($urandom), 8'($urandom));
            send_request(ACT_END, base + k, 16'($urandom), 8'($urandom));
        end

        for (int k = 0; k < 60; k++)
        begin
            if (k % 15 == 0)
            begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end
            r   = $urandom_range(0, 99);
            txn = $urandom;
            tag = 16'($urandom);
            cnt = 8'($urandom);
            if (r < 33)
                send_request(ACT_START, txn, tag, cnt);
            else if (r < 63)
            begin
                if ($urandom_range(0, 9) == 0)
                    cnt = 8'd0;
                send_request(ACT_RETIRE, txn, tag, cnt);
            end
            else if (r < 95)
            begin
                if ($urandom_range(0, 4) != 0)
                    void'(book.pick_live(txn));
                send_request(ACT_END, txn, tag, cnt);
            end
            else
                send_request(ACT_UNUSED, txn, tag, cnt);
        end
        in_valid <= 1'b0;

        while (book.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d requests, %0d results checked, %0d batches freed",
                 book.n_requests, book.n_results, book.n_freed);
        $display("active table full %0d, retired queue full %0d, unknown ends %0d",
                 book.n_table_full, book.n_queue_full, book.n_unknown);
        if (book.mismatches == 0 && book.pending() == 0)
            $display("epoch_reclamation_tracker_tb passed");
        else
            $display("epoch_reclamation_tracker_tb failed");
        $finish;
    end

endmodule
